// ----- design/lpdfa_pkg.sv -----
// Shared types and constants for the length-prefixed deframer with ack.
// Used by the front, queue, back, top-level and checker modules.
`default_nettype none
package lpdfa_pkg;

	localparam int HDR_BYTES       = 12;
	localparam int ACK_BYTES       = 16;
	localparam int ACK_WORD_END    = HDR_BYTES + 4;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Request codes.
	localparam logic [1:0] REQ_BYTE      = 2'd0;
	localparam logic [1:0] REQ_LINK_UP   = 2'd1;
	localparam logic [1:0] REQ_LINK_DOWN = 2'd2;

	// Result kinds.
	localparam logic [2:0] KIND_PAYLOAD = 3'd0;
	localparam logic [2:0] KIND_EMPTY   = 3'd1;
	localparam logic [2:0] KIND_ACK_RX  = 3'd2;
	localparam logic [2:0] KIND_TX_BYTE = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN = 3'd4;
	localparam logic [2:0] KIND_BAD_LEN = 3'd5;

	// Frame types.
	localparam logic [31:0] TYPE_DATA = 32'd0;
	localparam logic [31:0] TYPE_ACK  = 32'd1;

	typedef enum logic {
		PH_HDR,
		PH_PAY
	} phase_t;

	// One queued command: an optional single result, optionally followed by
	// a 16-byte ack frame.
	typedef struct packed {
		logic        has_res;
		logic [2:0]  kind;
		logic [7:0]  data;
		logic        last;
		logic [31:0] frame_id;
		logic [31:0] acked_id;
		logic        do_ack;
	} cmd_t;

endpackage
`default_nettype wire

// ----- design/lpdfa_front.sv -----
// Front end: takes link requests, parses frame headers and payload, and
// issues result commands into the queue. Depends on lpdfa_pkg.
`default_nettype none
module lpdfa_front import lpdfa_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] rx_byte,
	output cmd_t            cmd,
	output logic            cmd_push,
	input  wire logic       q_full
);

	phase_t      phase_q, phase_n;
	logic [31:0] count_q, count_n;
	logic [31:0] len_q, len_n;
	logic [31:0] id_q, id_n;
	logic [31:0] kind_q, kind_n;
	logic [31:0] ackw_q, ackw_n;
	logic        link_q, link_n;
	logic        accept;
	logic        do_end;
	logic        end_bad;
	logic        last;

	function automatic logic [31:0] set_byte(input logic [31:0] word,
		input logic [1:0] pos, input logic [7:0] b);
		logic [31:0] w;
		w = word;
		w[pos*8 +: 8] = b;
		return w;
	endfunction

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;
	assign cmd_push  = cmd.has_res || cmd.do_ack;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			count_q <= '0;
			len_q   <= '0;
			id_q    <= '0;
			kind_q  <= '0;
			ackw_q  <= '0;
			link_q  <= 1'b0;
		end else begin
			phase_q <= phase_n;
			count_q <= count_n;
			len_q   <= len_n;
			id_q    <= id_n;
			kind_q  <= kind_n;
			ackw_q  <= ackw_n;
			link_q  <= link_n;
		end
	end

	always_comb begin
		phase_n = phase_q;
		count_n = count_q;
		len_n   = len_q;
		id_n    = id_q;
		kind_n  = kind_q;
		ackw_n  = ackw_q;
		link_n  = link_q;
		do_end  = 1'b0;
		end_bad = 1'b0;
		last    = 1'b0;
		cmd     = '0;
		if (accept) begin
			unique case (req_type)
				REQ_LINK_UP: begin
					link_n = 1'b1;
				end
				REQ_LINK_DOWN: begin
					link_n  = 1'b0;
					phase_n = PH_HDR;
					count_n = '0;
				end
				REQ_BYTE: begin
					unique case (phase_q)
						PH_HDR: begin
							if (count_q < 32'd4)
								len_n = set_byte(len_q, count_q[1:0], rx_byte);
							else if (count_q < 32'd8)
								id_n = set_byte(id_q, count_q[1:0], rx_byte);
							else
								kind_n = set_byte(kind_q, count_q[1:0], rx_byte);
							count_n = count_q + 32'd1;
							if (count_n >= 32'(HDR_BYTES)) begin
								ackw_n = '0;
								if (len_n < 32'(HDR_BYTES)) begin
									do_end  = 1'b1;
									end_bad = 1'b1;
								end else if (len_n == 32'(HDR_BYTES)) begin
									do_end = 1'b1;
								end else begin
									phase_n = PH_PAY;
								end
							end
						end
						PH_PAY: begin
							last = (count_q + 32'd1 == len_q);
							if (kind_q == TYPE_DATA) begin
								cmd.has_res = 1'b1;
								cmd.kind    = KIND_PAYLOAD;
								cmd.data    = rx_byte;
								cmd.last    = last;
							end else if (kind_q == TYPE_ACK &&
									count_q < 32'(ACK_WORD_END)) begin
								ackw_n = set_byte(ackw_q, count_q[1:0], rx_byte);
							end
							count_n = count_q + 32'd1;
							do_end  = last;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		// Frame end: at most one closing result, then, if the link is up, the ack for data frames.
		if (do_end) begin
			phase_n = PH_HDR;
			count_n = '0;
			if (end_bad) begin
				cmd.has_res = 1'b1;
				cmd.kind    = KIND_BAD_LEN;
			end
			if (kind_n == TYPE_DATA) begin
				if (!end_bad && len_n == 32'(HDR_BYTES)) begin
					cmd.has_res = 1'b1;
					cmd.kind    = KIND_EMPTY;
				end
				cmd.do_ack = link_q;
			end else if (!end_bad) begin
				cmd.has_res = 1'b1;
				if (kind_n == TYPE_ACK) begin
					cmd.kind     = KIND_ACK_RX;
					cmd.acked_id = ackw_n;
				end else begin
					cmd.kind = KIND_UNKNOWN;
				end
			end
		end
		cmd.frame_id = id_n;
	end

endmodule
`default_nettype wire

// ----- design/lpdfa_queue.sv -----
// Short command queue between the front and back ends.
// Depends on lpdfa_pkg for the command type.
`default_nettype none
module lpdfa_queue import lpdfa_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      wr_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

// ----- design/lpdfa_back.sv -----
// Back end: expands queued commands into result beats, including the
// 16-byte ack frames, through a registered output stage. Depends on lpdfa_pkg.
`default_nettype none
module lpdfa_back import lpdfa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cmd_t             head,
	input  wire logic        q_empty,
	output logic             pop,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [2:0]       out_kind,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic [31:0]      frame_id,
	output logic [31:0]      acked_id
);

	logic        valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [31:0] fid_q;
	logic [31:0] aid_q;
	logic        res_done_q;
	logic [3:0]  idx_q;
	logic [31:0] tx_id_q;
	logic        load;
	logic        beat_is_res;
	logic        ack_end;
	logic [31:0] tx_word;
	logic [7:0]  tx_byte;

	assign load        = !q_empty && (!valid_q || !res_stall);
	assign beat_is_res = head.has_res && !res_done_q;
	assign ack_end     = (idx_q == 4'(ACK_BYTES - 1));
	assign pop         = load && (beat_is_res ? !head.do_ack : ack_end);

	always_comb begin
		case (idx_q[3:2])
			2'd0:    tx_word = 32'(ACK_BYTES);
			2'd1:    tx_word = tx_id_q;
			2'd2:    tx_word = TYPE_ACK;
			default: tx_word = head.frame_id;
		endcase
		tx_byte = tx_word[idx_q[1:0]*8 +: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			res_done_q <= 1'b0;
			idx_q      <= '0;
			tx_id_q    <= 32'd1;
		end else if (load) begin
			valid_q <= 1'b1;
			if (beat_is_res) begin
				res_done_q <= head.do_ack;
			end else if (ack_end) begin
				res_done_q <= 1'b0;
				idx_q      <= '0;
				tx_id_q    <= tx_id_q + 32'd1;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fid_q <= head.frame_id;
			if (beat_is_res) begin
				kind_q <= head.kind;
				byte_q <= head.data;
				last_q <= head.last;
				aid_q  <= head.acked_id;
			end else begin
				kind_q <= KIND_TX_BYTE;
				byte_q <= tx_byte;
				last_q <= ack_end;
				aid_q  <= '0;
			end
		end
	end

	assign res_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign frame_id  = fid_q;
	assign acked_id  = aid_q;

endmodule
`default_nettype wire

// ----- design/length_prefixed_deframer_with_ack_top.sv -----
// Path: the command for an accepted request is written into the queue, then
// loaded from the queue head into the registered output stage.
// Throughput: one request per cycle while the command queue has room; the
// output gives one beat per cycle while res_stall is low, and each sent ack
// frame adds 16 beats that back up into the queue and then the request side.
// Reset: arst_n clears the parser, link state, queue and output; tx id is 1.
`default_nettype none
module length_prefixed_deframer_with_ack_top import lpdfa_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [2:0]       out_kind,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic [31:0]      frame_id,
	output logic [31:0]      acked_id
);

	cmd_t cmd;
	cmd_t head;
	logic cmd_push;
	logic q_full;
	logic q_empty;
	logic pop;

	lpdfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.rx_byte   (rx_byte),
		.cmd       (cmd),
		.cmd_push  (cmd_push),
		.q_full    (q_full)
	);

	lpdfa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wr_cmd (cmd),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	lpdfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.frame_id  (frame_id),
		.acked_id  (acked_id)
	);

endmodule
`default_nettype wire

// ----- design/lpdfa_checker.sv -----
// Port-level checks for the deframer top level, bound to it below.
// Depends on lpdfa_pkg for result kind codes.
`default_nettype none
module lpdfa_checker import lpdfa_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_stall,
	input wire logic [1:0]  req_type,
	input wire logic [7:0]  rx_byte,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic [2:0]  out_kind,
	input wire logic [7:0]  out_byte,
	input wire logic        out_last,
	input wire logic [31:0] frame_id,
	input wire logic [31:0] acked_id
);

	// A stalled request beat stays offered and unchanged.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req_type) && $stable(rx_byte))
		else $error("stalled request beat changed");

	// A stalled result beat holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_kind) &&
			$stable(out_byte) && $stable(out_last) && $stable(frame_id) &&
			$stable(acked_id))
		else $error("stalled result beat changed");

	// An ack frame goes out as an unbroken run of transmit bytes.
	a_ack_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && out_kind == KIND_TX_BYTE && !out_last
			|=> res_valid && out_kind == KIND_TX_BYTE)
		else $error("ack frame run broken");

	// Only an ack-received result carries an acked id.
	a_acked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_kind != KIND_ACK_RX |-> acked_id == 32'd0)
		else $error("acked id set on wrong kind");

	// Only payload and transmit beats carry a byte or a last mark.
	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_kind != KIND_PAYLOAD && out_kind != KIND_TX_BYTE
			|-> out_byte == 8'd0 && !out_last)
		else $error("byte or last set on status result");

endmodule

bind length_prefixed_deframer_with_ack_top lpdfa_checker u_chk (.*);
`default_nettype wire
